/* rtl/grc_pkg.sv */
// Gradient color ramp: shared constants, register map codes and types.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package grc_pkg;

    localparam int NUM_STOPS  = 6;
    localparam int POS_W      = 17;
    localparam int CHAN_W     = 8;
    localparam int COLOR_W    = 32;
    localparam int STOP_W     = POS_W + COLOR_W;
    localparam int SEG_W      = 3;
    localparam int CNT_W      = 3;
    localparam int OPAC_W     = 9;
    localparam int FRAC_W     = 16;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = FRAC_W / DIV_BITS_PER_STAGE;
    localparam int SEARCH_STEPS = 3;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    localparam logic [REG_IDX_W-1:0] REG_STOP_ZERO    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STOP_ONE     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STOP_TWO     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STOP_THREE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STOP_FOUR    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STOP_FIVE    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STOPS_IN_USE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OPACITY      = 3'd7;

    localparam logic [STOP_W-1:0] STOP_ONE_RESET = 49'h1_0000_FFFF_FFFF;
    localparam logic [CNT_W-1:0]  STOPS_RESET    = 3'd2;
    localparam logic [CNT_W-1:0]  STOPS_MIN      = 3'd2;
    localparam logic [CNT_W-1:0]  STOPS_MAX      = 3'd6;
    localparam logic [OPAC_W-1:0] OPAC_MAX       = 9'd256;

    typedef logic [POS_W-1:0]   pos_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [SEG_W-1:0]   seg_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    typedef struct packed {
        pos_t   [NUM_STOPS-1:0] pos;
        color_t [NUM_STOPS-1:0] color;
        seg_t                   last_seg;
        logic   [OPAC_W-1:0]    opacity;
    } grc_cfg_t;

    typedef struct packed {
        seg_t seg;
        logic sat_zero;
        logic sat_one;
    } grc_side_t;

    typedef struct packed {
        pos_t              rem;
        pos_t              den;
        logic [FRAC_W-1:0] quo;
        grc_side_t         side;
    } grc_div_t;

endpackage

/* rtl/grc_if.sv */
// Gradient color ramp: valid/ready channel interfaces for sample and color words.
// Depends on grc_pkg.
`timescale 1ns / 1ps

interface grc_sample_if import grc_pkg::*; ();
    logic valid;
    logic ready;
    pos_t sample_pos;

    modport source (output valid, output sample_pos, input ready);
    modport sink   (input valid, input sample_pos, output ready);
endinterface

interface grc_color_if import grc_pkg::*; ();
    logic  valid;
    logic  ready;
    chan_t red;
    chan_t green;
    chan_t blue;
    chan_t alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                     input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                     output ready);
endinterface

/* rtl/grc_regs.sv */
// Gradient color ramp: APB register file for color stops, stop count and opacity.
// Depends on grc_pkg; presents cleaned-up configuration as grc_cfg_t.
`timescale 1ns / 1ps

module grc_regs import grc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output grc_cfg_t              cfg
);

    logic [STOP_W-1:0] stop_reg [NUM_STOPS];
    logic [CNT_W-1:0]  count_reg;
    logic [OPAC_W-1:0] opacity_reg;
    logic              wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[REG_LSB +: REG_IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STOPS; i++)
            begin
                stop_reg[i] <= (i == int'(REG_STOP_ONE)) ? STOP_ONE_RESET : '0;
            end
            count_reg   <= STOPS_RESET;
            opacity_reg <= OPAC_MAX;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_STOP_ZERO, REG_STOP_ONE, REG_STOP_TWO,
                REG_STOP_THREE, REG_STOP_FOUR, REG_STOP_FIVE:
                begin
                    stop_reg[idx] <= pwdata[STOP_W-1:0];
                end
                REG_STOPS_IN_USE:
                begin
                    count_reg <= pwdata[CNT_W-1:0];
                end
                REG_OPACITY:
                begin
                    opacity_reg <= pwdata[OPAC_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STOP_ZERO, REG_STOP_ONE, REG_STOP_TWO,
            REG_STOP_THREE, REG_STOP_FOUR, REG_STOP_FIVE:
            begin
                prdata = {{(APB_DATA_W-STOP_W){1'b0}}, stop_reg[idx]};
            end
            REG_STOPS_IN_USE:
            begin
                prdata = {{(APB_DATA_W-CNT_W){1'b0}}, count_reg};
            end
            REG_OPACITY:
            begin
                prdata = {{(APB_DATA_W-OPAC_W){1'b0}}, opacity_reg};
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_STOPS; i++)
        begin
            cfg.pos[i]   = stop_reg[i][STOP_W-1:COLOR_W];
            cfg.color[i] = stop_reg[i][COLOR_W-1:0];
        end
        // last usable segment index = clamp(count, 2, 6) - 2
        if (count_reg < STOPS_MIN)
        begin
            cfg.last_seg = '0;
        end
        else if (count_reg > STOPS_MAX)
        begin
            cfg.last_seg = STOPS_MAX - STOPS_MIN;
        end
        else
        begin
            cfg.last_seg = count_reg - STOPS_MIN;
        end
        cfg.opacity = (opacity_reg > OPAC_MAX) ? OPAC_MAX : opacity_reg;
    end

endmodule

/* rtl/grc_frac_div.sv */
// Gradient color ramp: pipelined restoring divider for the 16-bit local fraction.
// Depends on grc_pkg; DIV_STAGES register stages, DIV_BITS_PER_STAGE quotient bits each.
`timescale 1ns / 1ps

module grc_frac_div import grc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  grc_div_t in_data,
    output logic     out_valid,
    output grc_div_t out_data
);

    function automatic logic [POS_W:0] div_step(input pos_t rem, input pos_t den);
        logic [POS_W:0] twice;
        logic [POS_W:0] diff;
        twice = {rem, 1'b0};
        diff  = twice - {1'b0, den};
        if (twice >= {1'b0, den})
        begin
            return {1'b1, diff[POS_W-1:0]};
        end
        return {1'b0, twice[POS_W-1:0]};
    endfunction

    grc_div_t              stage_reg  [DIV_STAGES];
    grc_div_t              stage_next [DIV_STAGES];
    grc_div_t              stage_in   [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        grc_div_t       work;
        logic [POS_W:0] step;

        if (s == 0)
        begin : g_first
            assign stage_in[s] = in_data;
        end
        else
        begin : g_rest
            assign stage_in[s] = stage_reg[s-1];
        end

        always_comb
        begin
            work = stage_in[s];
            step = '0;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++)
            begin
                step     = div_step(work.rem, work.den);
                work.rem = step[POS_W-1:0];
                work.quo = {work.quo[FRAC_W-2:0], step[POS_W]};
            end
            stage_next[s] = work;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = stage_reg[DIV_STAGES-1];

endmodule

/* rtl/gradient_color_ramp_core.sv */
// Gradient color ramp top level: segment search, fraction divider, channel blend.
// Depends on grc_pkg, grc_if, grc_regs and grc_frac_div.
//
// Usage:
//   sample (valid/ready sink) carries one 17-bit gradient position per word.
//   color (valid/ready source) returns one RGBA word per sample, in order.
//   The APB port holds six color stops, the stop count and the opacity; write
//   them only while no sample is in flight.
// Throughput: one word per cycle unless color.ready stalls the pipeline. Every stage advances together.
// Pipeline: an accepted sample word passes one compare stage, one search stage,
//   eight divider stages of two quotient bits each, one blend stage and the
//   output register, which holds its color word.
// Stall: while a color word waits on color.ready the whole pipeline holds and
//   sample.ready is low; nothing is dropped or repeated.
// Reset: rst_n is asynchronous, active low. It empties the pipeline and loads
//   the register defaults: black at 0.0, white at 1.0, two stops, full opacity.
`timescale 1ns / 1ps

module gradient_color_ramp_core import grc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    grc_sample_if.sink            sample,
    grc_color_if.source           color
);

    function automatic seg_t find_segment(input logic [NUM_STOPS-1:0] lt,
                                          input logic [NUM_STOPS-1:0] gt,
                                          input seg_t last_seg);
        logic signed [SEG_W:0] left;
        logic signed [SEG_W:0] right;
        logic signed [SEG_W:0] mid;
        logic signed [SEG_W+1:0] sum;
        logic done;
        seg_t result;
        left   = '0;
        right  = $signed({1'b0, last_seg});
        mid    = '0;
        sum    = '0;
        done   = 1'b0;
        result = '0;
        for (int k = 0; k < SEARCH_STEPS; k++)
        begin
            if (!done && (left < right))
            begin
                sum = {left[SEG_W], left} + {right[SEG_W], right};
                mid = sum[SEG_W+1:1];
                if (lt[mid[SEG_W-1:0]])
                begin
                    right = mid - $signed((SEG_W+1)'(1));
                end
                else if (gt[mid[SEG_W-1:0] + 1'b1])
                begin
                    left = mid + $signed((SEG_W+1)'(1));
                end
                else
                begin
                    done   = 1'b1;
                    result = mid[SEG_W-1:0];
                end
            end
        end
        if (!done)
        begin
            if (left > $signed({1'b0, last_seg}))
            begin
                result = last_seg;
            end
            else
            begin
                result = left[SEG_W-1:0];
            end
        end
        return result;
    endfunction

    // floor(c0 + (c1 - c0) * f / 65536), f in 0..65536
    function automatic chan_t chan_mix(input chan_t c0, input chan_t c1,
                                       input logic [FRAC_W:0] f);
        logic signed [CHAN_W:0]          delta;
        logic signed [CHAN_W+FRAC_W+2:0] prod;
        logic signed [CHAN_W+FRAC_W+2:0] acc;
        delta = $signed({1'b0, c1}) - $signed({1'b0, c0});
        prod  = delta * $signed({1'b0, f});
        acc   = $signed({3'b000, c0, {FRAC_W{1'b0}}}) + prod;
        return acc[FRAC_W+CHAN_W-1:FRAC_W];
    endfunction

    grc_cfg_t cfg;

    grc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic adv;

    // stage A: position compares
    logic                 a_valid_reg;
    pos_t                 a_t_reg;
    logic [NUM_STOPS-1:0] a_lt_reg;
    logic [NUM_STOPS-1:0] a_gt_reg;
    logic [NUM_STOPS-1:0] a_lt_next;
    logic [NUM_STOPS-1:0] a_gt_next;

    // stage B: segment
    logic b_valid_reg;
    pos_t b_t_reg;
    seg_t b_seg_reg;
    seg_t b_seg_next;

    // divider feed
    pos_t     lo;
    pos_t     hi;
    grc_div_t div_in;
    logic     div_out_valid;
    grc_div_t div_out;

    // stage M: blended channels
    logic              m_valid_reg;
    chan_t             m_red_reg;
    chan_t             m_green_reg;
    chan_t             m_blue_reg;
    chan_t             m_alpha_reg;
    logic [FRAC_W:0]   frac;
    color_t            c_lo;
    color_t            c_hi;

    // output register
    logic                   out_valid_reg;
    chan_t                  out_red_reg;
    chan_t                  out_green_reg;
    chan_t                  out_blue_reg;
    chan_t                  out_alpha_reg;
    logic [CHAN_W+OPAC_W-1:0] alpha_prod;

    assign adv          = !out_valid_reg || color.ready;
    assign sample.ready = adv;

    always_comb
    begin
        for (int i = 0; i < NUM_STOPS; i++)
        begin
            a_lt_next[i] = sample.sample_pos < cfg.pos[i];
            a_gt_next[i] = sample.sample_pos > cfg.pos[i];
        end
    end

    assign b_seg_next = find_segment(a_lt_reg, a_gt_reg, cfg.last_seg);

    always_comb
    begin
        lo                   = cfg.pos[b_seg_reg];
        hi                   = cfg.pos[b_seg_reg + 1'b1];
        div_in.side.seg      = b_seg_reg;
        div_in.side.sat_zero = (hi <= lo) || (b_t_reg < lo);
        div_in.side.sat_one  = !div_in.side.sat_zero && (b_t_reg >= hi);
        div_in.rem           = b_t_reg - lo;
        div_in.den           = hi - lo;
        div_in.quo           = '0;
    end

    grc_frac_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (b_valid_reg),
        .in_data   (div_in),
        .out_valid (div_out_valid),
        .out_data  (div_out)
    );

    always_comb
    begin
        if (div_out.side.sat_zero)
        begin
            frac = '0;
        end
        else if (div_out.side.sat_one)
        begin
            frac = {1'b1, {FRAC_W{1'b0}}};
        end
        else
        begin
            frac = {1'b0, div_out.quo};
        end
        c_lo = cfg.color[div_out.side.seg];
        c_hi = cfg.color[div_out.side.seg + 1'b1];
    end

    assign alpha_prod = m_alpha_reg * cfg.opacity;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= sample.valid;
            b_valid_reg   <= a_valid_reg;
            m_valid_reg   <= div_out_valid;
            out_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_t_reg       <= sample.sample_pos;
            a_lt_reg      <= a_lt_next;
            a_gt_reg      <= a_gt_next;
            b_t_reg       <= a_t_reg;
            b_seg_reg     <= b_seg_next;
            m_red_reg     <= chan_mix(c_lo[31:24], c_hi[31:24], frac);
            m_green_reg   <= chan_mix(c_lo[23:16], c_hi[23:16], frac);
            m_blue_reg    <= chan_mix(c_lo[15:8],  c_hi[15:8],  frac);
            m_alpha_reg   <= chan_mix(c_lo[7:0],   c_hi[7:0],   frac);
            out_red_reg   <= m_red_reg;
            out_green_reg <= m_green_reg;
            out_blue_reg  <= m_blue_reg;
            out_alpha_reg <= alpha_prod[CHAN_W+7:8];
        end
    end

    assign color.valid = out_valid_reg;
    assign color.red   = out_red_reg;
    assign color.green = out_green_reg;
    assign color.blue  = out_blue_reg;
    assign color.alpha = out_alpha_reg;

    a_stall_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (color.valid && !color.ready) |-> !sample.ready
    ) else $error("sample accepted while color word stalled");

    a_seg_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_seg_reg <= cfg.last_seg)
    ) else $error("segment beyond last stop pair");

    a_compare_exclusive: assert property (
        @(posedge clk) disable iff (!rst_n)
        a_valid_reg |-> ((a_lt_reg & a_gt_reg) == '0)
    ) else $error("position both below and above a stop");

endmodule

/* dv/gradient_color_ramp_core_test.sv */
// Testbench for gradient_color_ramp_core: drives sample words, programs color stops over APB
// and checks every color word against an in-bench interpolation model.
// Depends on grc_pkg, grc_if and the gradient_color_ramp_core RTL.
`timescale 1ns / 1ps

module gradient_color_ramp_core_test;
    import grc_pkg::*;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SEND_GAPS,
        FLOW_RECV_STALLS,
        FLOW_BOTH_GAPS
    } flow_t;

    typedef struct packed {
        pos_t  pos;
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
    } ramp_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    grc_sample_if sample_ch ();
    grc_color_if  color_ch ();

    gradient_color_ramp_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .color   (color_ch)
    );

    // shadow of the register file
    logic [STOP_W-1:0] stop_word [NUM_STOPS];
    logic [CNT_W-1:0]  live_stops;
    logic [OPAC_W-1:0] opacity;

    pos_t       sample_backlog[$];
    ramp_word_t color_expect[$];
    flow_t      flow;
    logic       sample_taken;
    int         mismatches;
    int         hold_req;
    int         hold_seen;
    int         hold_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sample_ch.valid = 1'b0;
        sample_ch.sample_pos = '0;
        color_ch.ready = 1'b0;
        sample_taken = 1'b0;
        flow = FLOW_FREE;
        mismatches = 0;
        hold_req = 0;
        hold_seen = 0;
        hold_left = 0;
        for (int k = 0; k < NUM_STOPS; k++)
        begin
            stop_word[k] = '0;
        end
        stop_word[REG_STOP_ONE] = STOP_ONE_RESET;
        live_stops = STOPS_RESET;
        opacity = OPAC_MAX;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic ramp_word_t ramp_color(pos_t t);
        int         n;
        int         left;
        int         right;
        int         mid;
        int         seg;
        int         sh;
        longint     tv;
        longint     lo;
        longint     hi;
        longint     frac;
        longint     op;
        longint     c0;
        longint     c1;
        longint     v;
        chan_t      ch [4];
        ramp_word_t r;
        tv = longint'(t);
        n = int'(live_stops);
        if (n < int'(STOPS_MIN)) n = int'(STOPS_MIN);
        if (n > int'(STOPS_MAX)) n = int'(STOPS_MAX);
        left = 0;
        right = n - 2;
        seg = -1;
        while (left < right && seg < 0)
        begin
            mid = (left + right) / 2;
            if (tv < longint'(stop_word[mid][STOP_W-1:COLOR_W]))
                right = mid - 1;
            else if (tv > longint'(stop_word[mid+1][STOP_W-1:COLOR_W]))
                left = mid + 1;
            else
                seg = mid;
        end
        if (seg < 0)
        begin
            if (left < 0) seg = 0;
            else if (left > n - 2) seg = n - 2;
            else seg = left;
        end
        lo = longint'(stop_word[seg][STOP_W-1:COLOR_W]);
        hi = longint'(stop_word[seg+1][STOP_W-1:COLOR_W]);
        if (hi <= lo || tv < lo)
            frac = 0;
        else
        begin
            frac = ((tv - lo) * 65536) / (hi - lo);
            if (frac > 65536) frac = 65536;
        end
        for (int k = 0; k < 4; k++)
        begin
            sh = 24 - 8 * k;
            c0 = longint'(stop_word[seg][sh +: CHAN_W]);
            c1 = longint'(stop_word[seg+1][sh +: CHAN_W]);
            v = c0 * 65536 + (c1 - c0) * frac;
            if (v < 0) v = 0;
            ch[k] = chan_t'(v >> 16);
        end
        op = longint'(opacity);
        if (op > longint'(OPAC_MAX)) op = longint'(OPAC_MAX);
        r.pos = t;
        r.red = ch[0];
        r.green = ch[1];
        r.blue = ch[2];
        r.alpha = chan_t'((longint'(ch[3]) * op) >> 8);
        return r;
    endfunction

    function automatic logic pick_idle(bit is_sender);
        case (flow)
            FLOW_SEND_GAPS:   return is_sender && ($urandom_range(0, 99) < 87);
            FLOW_RECV_STALLS: return !is_sender && ($urandom_range(0, 99) < 87);
            FLOW_BOTH_GAPS:   return $urandom_range(0, 99) < 6;
            default:          return 1'b0;
        endcase
    endfunction

    always @(negedge clk)
    begin : drive_sample
        logic nv;
        pos_t np;
        nv = sample_ch.valid;
        np = sample_ch.sample_pos;
        if (sample_taken)
            nv = 1'b0;
        if (rst_n && !nv && sample_backlog.size() > 0 && !pick_idle(1'b1))
        begin
            np = sample_backlog.pop_front();
            nv = 1'b1;
        end
        sample_ch.valid <= nv;
        sample_ch.sample_pos <= np;
        color_ch.ready <= rst_n && (hold_left == 0) && !pick_idle(1'b0);
    end

    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= 100;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk)
    begin : watch_color
        ramp_word_t want;
        sample_taken <= rst_n && sample_ch.valid && sample_ch.ready;
        if (rst_n && sample_ch.valid && sample_ch.ready)
            color_expect.push_back(ramp_color(sample_ch.sample_pos));
        if (rst_n && color_ch.valid && color_ch.ready)
        begin
            if (color_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color word r=%0d g=%0d b=%0d a=%0d",
                             color_ch.red, color_ch.green, color_ch.blue, color_ch.alpha);
            end
            else
            begin
                want = color_expect.pop_front();
                if (color_ch.red !== want.red || color_ch.green !== want.green ||
                    color_ch.blue !== want.blue || color_ch.alpha !== want.alpha)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch t=%0d exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.pos, want.red, want.green, want.blue, want.alpha,
                                 color_ch.red, color_ch.green, color_ch.blue, color_ch.alpha);
                end
            end
        end
    end

    task automatic reg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'(idx) << REG_LSB;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx <= REG_STOP_FIVE)
            stop_word[idx] = value[STOP_W-1:0];
        else if (idx == REG_STOPS_IN_USE)
            live_stops = value[CNT_W-1:0];
        else if (idx == REG_OPACITY)
            opacity = value[OPAC_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_stop(int k, pos_t p, color_t c);
        logic [APB_DATA_W-STOP_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? (APB_DATA_W-STOP_W)'($urandom) : '0;
        reg_write(REG_STOP_ZERO + REG_IDX_W'(k), {junk, p, c});
    endtask

    task automatic wait_backlog();
        while (sample_backlog.size() > 0 || sample_ch.valid)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        wait_backlog();
        while (color_expect.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_setup();
        int     p [NUM_STOPS];
        int     tmp;
        int     r;
        color_t c;
        for (int k = 0; k < NUM_STOPS; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 70) p[k] = $urandom_range(0, 65536);
            else if (r < 80) p[k] = $urandom_range(0, 131071);
            else if (r < 90) p[k] = $urandom_range(0, 1) ? 65536 : 0;
            else p[k] = (k > 0) ? p[k-1] : 0;
        end
        if ($urandom_range(0, 99) < 80)
        begin
            for (int i = 0; i < NUM_STOPS - 1; i++)
                for (int j = 0; j < NUM_STOPS - 1 - i; j++)
                    if (p[j] > p[j+1])
                    begin
                        tmp = p[j];
                        p[j] = p[j+1];
                        p[j+1] = tmp;
                    end
        end
        for (int k = 0; k < NUM_STOPS; k++)
        begin
            r = $urandom_range(0, 9);
            c = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : color_t'($urandom);
            write_stop(k, pos_t'(p[k]), c);
        end
        if ($urandom_range(0, 99) < 70)
            reg_write(REG_STOPS_IN_USE, APB_DATA_W'($urandom_range(2, 6)));
        else
            reg_write(REG_STOPS_IN_USE, {$urandom, $urandom});
        case ($urandom_range(0, 4))
            0: reg_write(REG_OPACITY, '0);
            1: reg_write(REG_OPACITY, APB_DATA_W'(OPAC_MAX));
            2: reg_write(REG_OPACITY, APB_DATA_W'(511));
            default: reg_write(REG_OPACITY, {$urandom, $urandom});
        endcase
    endtask

    function automatic pos_t random_pos();
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            p = int'(stop_word[$urandom_range(0, NUM_STOPS - 1)][STOP_W-1:COLOR_W]);
            p = p + $urandom_range(0, 2) - 1;
            return pos_t'(p);
        end
        else if (r < 75)
            return pos_t'($urandom_range(0, 65536));
        else if (r < 85)
            return ($urandom_range(0, 2) == 0) ? pos_t'(0) :
                   ($urandom_range(0, 1) == 0) ? pos_t'(65536) : pos_t'(131071);
        return pos_t'($urandom_range(0, 131071));
    endfunction

    initial begin
        @(posedge rst_n);
        @(posedge clk);

        // reset defaults: black at 0.0, white at 1.0
        foreach (sample_backlog[i]) ;
        sample_backlog = '{0, 1, 32768, 65535, 65536, 65537, 131071};
        wait_idle();

        // six ascending stops, half opacity
        write_stop(0, 0, 32'hFF00_0080);
        write_stop(1, 10000, 32'h00FF_00FF);
        write_stop(2, 20000, 32'h0000_FFFF);
        write_stop(3, 40000, 32'hFFFF_FFFF);
        write_stop(4, 50000, 32'h1234_5678);
        write_stop(5, 65536, 32'h0000_0000);
        reg_write(REG_STOPS_IN_USE, APB_DATA_W'(STOPS_MAX));
        reg_write(REG_OPACITY, APB_DATA_W'(128));
        sample_backlog = '{0, 10000, 15000, 40000, 45000, 65536, 131071};
        wait_idle();

        // zero-length segment, count below range, opacity above range
        write_stop(0, 30000, 32'hFFFF_FFFF);
        write_stop(1, 30000, 32'h0000_0000);
        reg_write(REG_STOPS_IN_USE, '0);
        reg_write(REG_OPACITY, APB_DATA_W'(511));
        sample_backlog = '{0, 30000, 65536};
        wait_idle();
        reg_write(REG_STOPS_IN_USE, APB_DATA_W'(1));
        reg_write(REG_OPACITY, '0);
        sample_backlog.push_back(40000);
        wait_idle();

        // unordered stops, count above range
        write_stop(0, 60000, 32'h8080_8080);
        write_stop(1, 5000, 32'hFF00_FF00);
        write_stop(2, 40000, 32'h00FF_00FF);
        write_stop(3, 131071, 32'hFFFF_FFFF);
        write_stop(4, 20000, 32'h0102_0304);
        write_stop(5, 0, 32'hFEDC_BA98);
        reg_write(REG_STOPS_IN_USE, APB_DATA_W'(7));
        reg_write(REG_OPACITY, APB_DATA_W'(200));
        sample_backlog = '{0, 20000, 45000, 70000, 131071};
        wait_idle();

        for (int ph = 0; ph < 10; ph++)
        begin
            random_setup();
            for (int chunk = 0; chunk < 5; chunk++)
            begin
                if (ph == 0 && chunk == 0)
                begin
                    // long receiver hold-off: pipeline fills, sample.ready drops
                    flow = FLOW_FREE;
                    hold_req++;
                end
                else
                    flow = flow_t'($urandom_range(0, 3));
                for (int i = 0; i < 25; i++)
                    sample_backlog.push_back(random_pos());
                wait_backlog();
            end
            wait_idle();
        end

        flow = FLOW_FREE;
        wait_idle();
        repeat (30) @(posedge clk);
        if (mismatches == 0 && color_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* gradient_color_ramp_core.f */
rtl/grc_pkg.sv
rtl/grc_if.sv
rtl/grc_regs.sv
rtl/grc_frac_div.sv
rtl/gradient_color_ramp_core.sv
dv/gradient_color_ramp_core_test.sv
